### rtl/calendar_date_offset_unit_assert.svh
// ----------------------------------------------------------------------------
// Calendar date offset unit - assertion macros
// Shared assertion macros for the checker of the date offset unit.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_OFFSET_UNIT_ASSERT_SVH
`define CALENDAR_DATE_OFFSET_UNIT_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define CDO_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define CDO_ASSERT(lbl, prop, msg) \
  `CDO_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/cdo_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - package
// Transaction types, status codes, controller types and calendar tables.
// ----------------------------------------------------------------------------
package cdo_pkg;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [8:0]  DAYS_COMMON = 9'd365;
  localparam logic [8:0]  DAYS_LEAP   = 9'd366;
  localparam logic [4:0]  FEB_LEAP    = 5'd29;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  // multiplicative inverse of 25 mod 2^14 and the divisibility bound
  localparam logic [13:0] INV25       = 14'd7209;
  localparam logic [13:0] DIV25_MAX   = 14'd655;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_DATE = 2'd1;
  localparam logic [1:0] STAT_BAD_YEAR = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [8:0]  offset_days;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_leap;
    logic [8:0]  day_of_year;
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAP,
    ST_CHECK,
    ST_YLEAP,
    ST_YSTEP,
    ST_SLEAP,
    ST_SADD,
    ST_FIN,
    ST_MONTH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic leap_start;
    logic leap_load;
    logic check;
    logic year_step;
    logic sub_add;
    logic set_bad_year;
    logic month_init;
    logic month_step;
    logic out_load;
  } cdo_cmd_t;

  typedef struct packed {
    logic sub;
    logic date_ok;
    logic year_more;
    logic yr_zero;
    logic yr_range_ok;
    logic month_more;
  } cdo_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? FEB_LEAP : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // divisible by 4 and not by 100, or divisible by 400 (400 = 16 * 25)
  function automatic logic leap_of(input logic [13:0] y);
    logic [13:0] p;
    logic        div25;
    p     = 14'(y * INV25);
    div25 = (p <= DIV25_MAX);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? DAYS_LEAP : DAYS_COMMON;
  endfunction

endpackage

### rtl/cdo_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - controller
// Sequencer for validation, year rollover and month search; owns handshakes.
// ----------------------------------------------------------------------------
module cdo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  cdo_pkg::cdo_stat_t stat_i,
  output cdo_pkg::cdo_cmd_t  cmd_o
);

  cdo_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign in_stall_o  = (state_q != cdo_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cdo_pkg::ST_IDLE:  if (in_valid_i) state_d = cdo_pkg::ST_LEAP;
      cdo_pkg::ST_LEAP:  state_d = cdo_pkg::ST_CHECK;
      cdo_pkg::ST_CHECK: state_d = stat_i.date_ok ? cdo_pkg::ST_YLEAP : cdo_pkg::ST_DONE;
      cdo_pkg::ST_YLEAP: state_d = cdo_pkg::ST_YSTEP;
      cdo_pkg::ST_YSTEP: begin
        if (!stat_i.year_more) begin
          state_d = cdo_pkg::ST_FIN;
        end else if (stat_i.sub) begin
          state_d = cdo_pkg::ST_SLEAP;
        end else begin
          state_d = cdo_pkg::ST_YLEAP;
        end
      end
      cdo_pkg::ST_SLEAP: state_d = stat_i.yr_zero ? cdo_pkg::ST_FIN : cdo_pkg::ST_SADD;
      cdo_pkg::ST_SADD:  state_d = cdo_pkg::ST_YSTEP;
      cdo_pkg::ST_FIN:   state_d = stat_i.yr_range_ok ? cdo_pkg::ST_MONTH : cdo_pkg::ST_DONE;
      cdo_pkg::ST_MONTH: if (!stat_i.month_more) state_d = cdo_pkg::ST_DONE;
      cdo_pkg::ST_DONE:  if (out_free) state_d = cdo_pkg::ST_IDLE;
      default:           state_d = cdo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      cdo_pkg::ST_IDLE:  cmd_o.load_in = in_valid_i;
      cdo_pkg::ST_LEAP: begin
        cmd_o.leap_load  = 1'b1;
        cmd_o.leap_start = 1'b1;
      end
      cdo_pkg::ST_CHECK: cmd_o.check = 1'b1;
      cdo_pkg::ST_YLEAP: cmd_o.leap_load = 1'b1;
      cdo_pkg::ST_YSTEP: cmd_o.year_step = stat_i.year_more;
      cdo_pkg::ST_SLEAP: cmd_o.leap_load = !stat_i.yr_zero;
      cdo_pkg::ST_SADD:  cmd_o.sub_add = 1'b1;
      cdo_pkg::ST_FIN: begin
        cmd_o.leap_load    = stat_i.yr_range_ok;
        cmd_o.month_init   = stat_i.yr_range_ok;
        cmd_o.set_bad_year = !stat_i.yr_range_ok;
      end
      cdo_pkg::ST_MONTH: cmd_o.month_step = stat_i.month_more;
      cdo_pkg::ST_DONE:  cmd_o.out_load = out_free;
      default:           cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/cdo_datapath.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - datapath
// Operand registers, leap unit, day counter, year and month registers,
// result register.
// ----------------------------------------------------------------------------
module cdo_datapath (
  input  logic                clk_i,
  input  cdo_pkg::in_item_t   in_data_i,
  input  cdo_pkg::cdo_cmd_t   cmd_i,
  output cdo_pkg::cdo_stat_t  stat_o,
  output cdo_pkg::out_item_t  out_data_o
);

  logic               req_q;
  logic [4:0]         day_q;
  logic [3:0]         month_q;
  logic [13:0]        year_q;
  logic [8:0]         off_q;
  logic [13:0]        yr_q, yr_d;
  logic signed [10:0] kq_q, kq_d;
  logic               leap_q, start_leap_q;
  logic [8:0]         doy_q, doy_d;
  logic [3:0]         rm_q, rm_d;
  logic [1:0]         status_q, status_d;
  cdo_pkg::out_item_t out_q;

  logic               leap_cur;
  logic [4:0]         start_mlen;
  logic [8:0]         doy_calc;
  logic signed [10:0] ylen_s, mlen_s, doy_s, off_s;

  assign leap_cur   = cdo_pkg::leap_of(yr_q);
  assign start_mlen = cdo_pkg::month_len(month_q, leap_q);
  assign doy_calc   = cdo_pkg::days_before(month_q)
                    + {8'd0, (leap_q && (month_q > cdo_pkg::MONTH_FEB))}
                    + {4'd0, day_q};
  assign ylen_s     = $signed({2'b00, cdo_pkg::year_len(leap_q)});
  assign mlen_s     = $signed({6'd0, cdo_pkg::month_len(rm_q, leap_q)});
  assign doy_s      = $signed({2'b00, doy_calc});
  assign off_s      = $signed({2'b00, off_q});

  assign stat_o.sub         = req_q;
  assign stat_o.date_ok     = (month_q != 4'd0) && (month_q <= cdo_pkg::MONTH_MAX)
                            && (year_q != 14'd0) && (year_q <= cdo_pkg::YEAR_MAX)
                            && (day_q != 5'd0) && (day_q <= start_mlen);
  assign stat_o.year_more   = req_q ? ((kq_q <= 11'sd0) && (yr_q != 14'd0))
                                    : ((kq_q > ylen_s) && (yr_q <= cdo_pkg::YEAR_MAX));
  assign stat_o.yr_zero     = (yr_q == 14'd0);
  assign stat_o.yr_range_ok = (yr_q != 14'd0) && (yr_q <= cdo_pkg::YEAR_MAX);
  assign stat_o.month_more  = (rm_q < cdo_pkg::MONTH_MAX) && (kq_q > mlen_s);

  always_comb begin
    yr_d     = yr_q;
    kq_d     = kq_q;
    doy_d    = doy_q;
    rm_d     = rm_q;
    status_d = status_q;
    if (cmd_i.load_in) begin
      yr_d = in_data_i.start_year;
    end
    if (cmd_i.check) begin
      doy_d    = stat_o.date_ok ? doy_calc : 9'd0;
      kq_d     = req_q ? (doy_s - off_s) : (doy_s + off_s);
      status_d = stat_o.date_ok ? cdo_pkg::STAT_OK : cdo_pkg::STAT_BAD_DATE;
    end
    if (cmd_i.year_step) begin
      if (req_q) begin
        yr_d = yr_q - 14'd1;
      end else begin
        yr_d = yr_q + 14'd1;
        kq_d = kq_q - ylen_s;
      end
    end
    if (cmd_i.sub_add) begin
      kq_d = kq_q + ylen_s;
    end
    if (cmd_i.set_bad_year) begin
      status_d = cdo_pkg::STAT_BAD_YEAR;
    end
    if (cmd_i.month_init) begin
      rm_d = 4'd1;
    end
    if (cmd_i.month_step) begin
      kq_d = kq_q - mlen_s;
      rm_d = rm_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q   <= in_data_i.req_type;
      day_q   <= in_data_i.start_day;
      month_q <= in_data_i.start_month;
      year_q  <= in_data_i.start_year;
      off_q   <= in_data_i.offset_days;
    end
    if (cmd_i.leap_load) begin
      leap_q <= leap_cur;
    end
    if (cmd_i.leap_start) begin
      start_leap_q <= leap_cur;
    end
    yr_q     <= yr_d;
    kq_q     <= kq_d;
    doy_q    <= doy_d;
    rm_q     <= rm_d;
    status_q <= status_d;
    if (cmd_i.out_load) begin
      out_q.status      <= status_q;
      out_q.is_leap     <= start_leap_q;
      out_q.day_of_year <= doy_q;
      if (status_q == cdo_pkg::STAT_OK) begin
        out_q.result_day   <= kq_q[4:0];
        out_q.result_month <= rm_q;
        out_q.result_year  <= yr_q;
      end else begin
        out_q.result_day   <= 5'd0;
        out_q.result_month <= 4'd0;
        out_q.result_year  <= 14'd0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/calendar_date_offset_unit.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - top level
// Gregorian date validation, ordinal day and shift by up to 511 days.
// ----------------------------------------------------------------------------
// One transaction at a time: the block takes a date and an offset, then
// stalls its input until the result has been placed in the output register;
// the next transaction is accepted while that result still waits to be
// taken. Accept leads through the leap and check states, the year leap and
// year step states for every year boundary crossed (backward also the
// sub leap and add states) and the final month search, one month length per
// cycle, which dominates. Invalid dates go from the check to the result.
module calendar_date_offset_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cdo_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdo_pkg::out_item_t out_data_o
);

  cdo_pkg::cdo_cmd_t  cmd;
  cdo_pkg::cdo_stat_t stat;

  cdo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdo_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/cdo_checker.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "calendar_date_offset_unit_assert.svh"

module cdo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input cdo_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cdo_pkg::out_item_t out_data_o
);

  logic in_acc;
  logic in_seen;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign in_seen = in_data_i.req_type || !in_data_i.req_type;

  `CDO_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  `CDO_ASSERT(a_busy_after_accept, in_acc && in_seen |=> in_stall_o, "input not stalled after accept")

  `CDO_ASSERT(a_err_zero, out_valid_o && (out_data_o.status != cdo_pkg::STAT_OK) |-> (out_data_o.result_day == 5'd0) && (out_data_o.result_month == 4'd0) && (out_data_o.result_year == 14'd0), "error result carries a date")

  `CDO_ASSERT(a_doy_valid, out_valid_o |-> ((out_data_o.status == cdo_pkg::STAT_BAD_DATE) == (out_data_o.day_of_year == 9'd0)), "ordinal day inconsistent with status")

  `CDO_ASSERT(a_ok_date, out_valid_o && (out_data_o.status == cdo_pkg::STAT_OK) |-> (out_data_o.result_day != 5'd0) && (out_data_o.result_month != 4'd0) && (out_data_o.result_month <= cdo_pkg::MONTH_MAX) && (out_data_o.result_year != 14'd0), "ok result with empty date")

endmodule

bind calendar_date_offset_unit cdo_checker u_checker (.*);

### tb/calendar_date_offset_unit_test.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - testbench
// Drives dates and day offsets into the unit and checks each result against
// a table entry or a date-shift predictor: directed edge dates first, then
// random dates, idling both channels at random in all but the last phase.
// ----------------------------------------------------------------------------
module calendar_date_offset_unit_test;
  import cdo_pkg::*;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   ITEMS_PER_PHASE = 600;
  localparam out_item_t NO_RESULT = '0;
  localparam int   MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t result;
  } date_case_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  out_item_t pending_dates [$];
  out_item_t want;
  int        bad_results = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  date_case_t directed_cases [$] = '{
    '{'{OP_ADD, 5'd1, 4'd1, 14'd1, 9'd0}, 1'b1,
      '{STAT_OK, 1'b0, 9'd1, 5'd1, 4'd1, 14'd1}},
    '{'{OP_ADD, 5'd31, 4'd12, 14'd9999, 9'd0}, 1'b1,
      '{STAT_OK, 1'b0, 9'd365, 5'd31, 4'd12, 14'd9999}},
    '{'{OP_ADD, 5'd31, 4'd12, 14'd9999, 9'd1}, 1'b1,
      '{STAT_BAD_YEAR, 1'b0, 9'd365, 5'd0, 4'd0, 14'd0}},
    '{'{OP_SUB, 5'd1, 4'd1, 14'd1, 9'd1}, 1'b1,
      '{STAT_BAD_YEAR, 1'b0, 9'd1, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd0, 4'd1, 14'd2000, 9'd0}, 1'b1,
      '{STAT_BAD_DATE, 1'b1, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd1, 4'd0, 14'd2000, 9'd0}, 1'b1,
      '{STAT_BAD_DATE, 1'b1, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd1, 4'd13, 14'd2023, 9'd5}, 1'b1,
      '{STAT_BAD_DATE, 1'b0, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_SUB, 5'd31, 4'd15, 14'd16383, 9'd511}, 1'b1,
      '{STAT_BAD_DATE, 1'b0, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd1, 4'd1, 14'd0, 9'd0}, 1'b1,
      '{STAT_BAD_DATE, 1'b1, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd1, 4'd1, 14'd10000, 9'd0}, 1'b1,
      '{STAT_BAD_DATE, 1'b1, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd29, 4'd2, 14'd2000, 9'd0}, 1'b1,
      '{STAT_OK, 1'b1, 9'd60, 5'd29, 4'd2, 14'd2000}},
    '{'{OP_ADD, 5'd29, 4'd2, 14'd1900, 9'd0}, 1'b1,
      '{STAT_BAD_DATE, 1'b0, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd30, 4'd2, 14'd2024, 9'd0}, 1'b1,
      '{STAT_BAD_DATE, 1'b1, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd31, 4'd4, 14'd2023, 9'd0}, 1'b1,
      '{STAT_BAD_DATE, 1'b0, 9'd0, 5'd0, 4'd0, 14'd0}},
    '{'{OP_ADD, 5'd31, 4'd12, 14'd2023, 9'd1}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 5'd1, 4'd1, 14'd2024, 9'd1}, 1'b0, NO_RESULT},
    '{'{OP_ADD, 5'd29, 4'd2, 14'd2024, 9'd365}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 5'd1, 4'd3, 14'd2024, 9'd365}, 1'b0, NO_RESULT},
    '{'{OP_ADD, 5'd15, 4'd6, 14'd2000, 9'd511}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 5'd15, 4'd6, 14'd2000, 9'd511}, 1'b0, NO_RESULT},
    '{'{OP_ADD, 5'd31, 4'd1, 14'd9999, 9'd365}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 5'd31, 4'd12, 14'd1, 9'd365}, 1'b0, NO_RESULT},
    '{'{OP_ADD, 5'd28, 4'd2, 14'd2100, 9'd1}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 5'd31, 4'd12, 14'd2000, 9'd0}, 1'b0, NO_RESULT},
    '{'{OP_SUB, 5'd31, 4'd12, 14'd9999, 9'd511}, 1'b0, NO_RESULT}
  };

  calendar_date_offset_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int m, input bit leap);
    if (m == 2 && leap) begin
      return 29;
    end
    return MONTH_DAYS[m];
  endfunction

  function automatic int days_in_year(input int y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic out_item_t shift_date(input in_item_t item);
    out_item_t r;
    int d, m, y, off, doy, yr, kq, rm;
    bit leap;
    d    = item.start_day;
    m    = item.start_month;
    y    = item.start_year;
    off  = item.offset_days;
    leap = leap_year(y);
    r         = '0;
    r.status  = STAT_BAD_DATE;
    r.is_leap = leap;
    if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > days_in_month(m, leap)) begin
      return r;
    end
    doy = d;
    for (int i = 1; i < m; i++) begin
      doy += days_in_month(i, leap);
    end
    r.day_of_year = 9'(doy);
    yr = y;
    if (item.req_type == OP_ADD) begin
      kq = doy + off;
      while (kq > days_in_year(yr) && yr <= 9999) begin
        kq -= days_in_year(yr);
        yr++;
      end
    end else begin
      kq = doy - off;
      while (kq <= 0 && yr >= 1) begin
        yr--;
        if (yr < 1) break;
        kq += days_in_year(yr);
      end
    end
    if (yr < 1 || yr > 9999) begin
      r.status = STAT_BAD_YEAR;
      return r;
    end
    leap = leap_year(yr);
    rm = 1;
    while (rm < 12 && kq > days_in_month(rm, leap)) begin
      kq -= days_in_month(rm, leap);
      rm++;
    end
    r.status       = STAT_OK;
    r.result_day   = 5'(kq);
    r.result_month = 4'(rm);
    r.result_year  = 14'(yr);
    return r;
  endfunction

  function automatic bit same_result(input out_item_t a, input out_item_t b);
    return a.status == b.status && a.is_leap == b.is_leap &&
           a.day_of_year == b.day_of_year && a.result_day == b.result_day &&
           a.result_month == b.result_month && a.result_year == b.result_year;
  endfunction

  // mostly valid dates near interesting years, some raw noise
  function automatic in_item_t random_request();
    in_item_t item;
    int y, m, d, len;
    item.req_type = $urandom_range(1, 0) ? OP_SUB : OP_ADD;
    if ($urandom_range(99) < 12) begin
      item.start_day   = 5'($urandom);
      item.start_month = 4'($urandom);
      item.start_year  = 14'($urandom);
      item.offset_days = 9'($urandom);
      return item;
    end
    case ($urandom_range(5))
      0:       y = $urandom_range(3, 1);
      1:       y = $urandom_range(9999, 9997);
      2:       y = $urandom_range(24, 1) * 400;
      3:       y = $urandom_range(99, 1) * 100;
      default: y = $urandom_range(9999, 1);
    endcase
    m   = $urandom_range(12, 1);
    len = days_in_month(m, leap_year(y));
    case ($urandom_range(3))
      0:       d = 1;
      1:       d = len;
      default: d = $urandom_range(len, 1);
    endcase
    item.start_day   = 5'(d);
    item.start_month = 4'(m);
    item.start_year  = 14'(y);
    item.offset_days = ($urandom_range(7) == 0) ? 9'($urandom_range(511, 366))
                                                : 9'($urandom_range(365, 0));
    return item;
  endfunction

  task automatic send_item(input in_item_t item, input out_item_t expected);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_dates.push_back(expected);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_dates.size() == 0) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("unexpected result transaction: %h", out_data_o);
          end
        end else begin
          want = pending_dates.pop_front();
          if (!same_result(want, out_data_o)) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("mismatch: expected st %0d leap %0d doy %0d date %0d/%0d/%0d",
                       want.status, want.is_leap, want.day_of_year,
                       want.result_day, want.result_month, want.result_year);
              $display("          actual   st %0d leap %0d doy %0d date %0d/%0d/%0d",
                       out_data_o.status, out_data_o.is_leap, out_data_o.day_of_year,
                       out_data_o.result_day, out_data_o.result_month,
                       out_data_o.result_year);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    in_item_t req;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 66;
    foreach (directed_cases[i]) begin
      send_item(directed_cases[i].stim,
                directed_cases[i].known ? directed_cases[i].result
                                        : shift_date(directed_cases[i].stim));
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 36 : 0;
      repeat (ITEMS_PER_PHASE) begin
        req = random_request();
        send_item(req, shift_date(req));
      end
    end
    in_valid_i <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (bad_results == 0 && pending_dates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
